// ===== src/bdeq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the bounded double-ended queue.
// No dependencies; imported by the output buffer, the top level and the bench.
package bdeq_pkg;

    localparam int VALUE_W  = 32;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;

    // Output buffer depth, a power of two
    localparam int OBUF_DEPTH = 4;
    localparam int OBUF_PTR_W = $clog2(OBUF_DEPTH);
    localparam int OBUF_CNT_W = $clog2(OBUF_DEPTH + 1);

    // Command codes carried on s_tuser
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_REAR   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LIST       = 3'd4;

    // Status codes carried on m_tuser
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] data;
        logic                      last;
    } res_t;

endpackage

// ===== src/bdeq_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bdeq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/bdeq_obuf.sv =====
`timescale 1ns / 1ps
// Small result FIFO between the queue controller and the master port.
// Depends on bdeq_pkg (res_t, OBUF_* constants).
module bdeq_obuf (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               push_valid,
    input  bdeq_pkg::res_t                     push_res,
    input  logic                               pop_ready,
    output logic                               head_valid,
    output bdeq_pkg::res_t                     head_res,
    output logic [bdeq_pkg::OBUF_CNT_W-1:0]    count,
    output logic                               full
);
    import bdeq_pkg::*;

    res_t                  slot_reg [OBUF_DEPTH];
    logic [OBUF_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OBUF_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OBUF_CNT_W-1:0] count_reg, count_next;
    logic                  do_pop;

    assign head_valid = (count_reg != '0);
    assign head_res   = slot_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign full       = (count_reg == OBUF_CNT_W'(OBUF_DEPTH));
    assign do_pop     = head_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push_valid ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push_valid && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !push_valid) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            slot_reg[wr_ptr_reg] <= push_res;
        end
    end

endmodule

// ===== src/bounded_double_ended_queue_top.sv =====
`timescale 1ns / 1ps
// Bounded double-ended queue: controller, ring store and result buffer.
// Depends on bdeq_pkg, bdeq_ram and bdeq_obuf.
//
// Usage
//   Slave channel: one word per command. s_tuser carries the command (push front,
//   push rear, pop front, pop rear, list), s_tdata the word to push.
//   Master channel: one result word per push or pop, one per stored entry for a
//   listing (front to rear), or a single empty result when listing an empty queue.
//   m_tuser carries the status (ok, empty, full), m_tdata the popped or listed
//   word (zero otherwise), m_tlast marks the final result of a command.
// Timing
//   A push writes the ring store and posts its result to the FIFO in the same cycle.
//   A pop reads the ring store, then posts the read word; no command is taken
//   while that read is in flight. A listing issues one store read a cycle while
//   the FIFO has room and holds the slave side until its last read has posted;
//   the single read port of the store sets that rate. Results leave through a
//   four-word FIFO that registers each one before it reaches the master side;
//   pop and listing words first pass the read register of the store.
// Reset and stalls
//   Reset empties the queue and the result FIFO; the ring store keeps stale data
//   that is never read before being written. When the receiver stalls, the FIFO
//   fills and then s_tready drops, or a listing pauses, until space returns.
module bounded_double_ended_queue_top #(
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic signed [bdeq_pkg::VALUE_W-1:0]   s_tdata,  // [31:0] value
    input  logic [bdeq_pkg::MODE_W-1:0]           s_tuser,  // [2:0] mode
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic signed [bdeq_pkg::VALUE_W-1:0]   m_tdata,  // [31:0] data
    output logic [bdeq_pkg::STATUS_W-1:0]         m_tuser,  // [1:0] status
    output logic                                  m_tlast
);
    import bdeq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam logic [OCC_W-1:0] OCC_FULL   = OCC_W'(DEPTH);
    localparam logic [IDX_W:0]   DEPTH_EXT  = (IDX_W + 1)'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LIST = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;
    logic [IDX_W-1:0]  list_idx_reg, list_idx_next;
    logic              rd_pend_reg, rd_pend_next;
    logic              rd_last_reg, rd_last_next;

    logic              ram_we, ram_re;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    logic              accept;
    logic              imm_valid;
    res_t              imm_res;
    logic              ob_push;
    res_t              ob_push_res;
    logic              ob_head_valid;
    res_t              ob_head_res;
    logic [OBUF_CNT_W-1:0] ob_count;
    logic              ob_full;
    logic [OBUF_CNT_W:0]   ob_load;
    logic              issue_ok;
    logic              q_empty, q_full;

    // Ring index addition; both operands stay below DEPTH
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                  input logic [IDX_W-1:0] b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_EXT) begin
            s = s - DEPTH_EXT;
        end
        return s[IDX_W-1:0];
    endfunction

    assign q_empty  = (occ_reg == '0);
    assign q_full   = (occ_reg >= OCC_FULL);
    // Words in the FIFO plus a store read still in flight
    assign ob_load  = {1'b0, ob_count} + {{OBUF_CNT_W{1'b0}}, rd_pend_reg};
    assign issue_ok = (ob_load < (OBUF_CNT_W + 1)'(OBUF_DEPTH));
    // Take a command only when idle, with no read in flight and room for its result
    assign s_tready = (state_reg == S_IDLE) && !rd_pend_reg && !ob_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        occ_next      = occ_reg;
        list_idx_next = list_idx_reg;
        rd_pend_next  = 1'b0;
        rd_last_next  = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_waddr     = head_reg;
        ram_raddr     = head_reg;
        imm_valid     = 1'b0;
        imm_res       = '{status: ST_OK, data: '0, last: 1'b1};

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (s_tuser)
                        MODE_PUSH_FRONT: begin
                            imm_valid = 1'b1;
                            if (q_full) begin
                                imm_res.status = ST_FULL;
                            end else begin
                                head_next = (head_reg == '0) ? LAST_SLOT
                                                             : head_reg - 1'b1;
                                ram_we    = 1'b1;
                                ram_waddr = head_next;
                                occ_next  = occ_reg + 1'b1;
                            end
                        end
                        MODE_PUSH_REAR: begin
                            imm_valid = 1'b1;
                            if (q_full) begin
                                imm_res.status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = ring_add(head_reg, IDX_W'(occ_reg));
                                occ_next  = occ_reg + 1'b1;
                            end
                        end
                        MODE_POP_FRONT: begin
                            if (q_empty) begin
                                imm_valid      = 1'b1;
                                imm_res.status = ST_EMPTY;
                            end else begin
                                ram_re       = 1'b1;
                                ram_raddr    = head_reg;
                                head_next    = (head_reg == LAST_SLOT) ? '0
                                                                       : head_reg + 1'b1;
                                occ_next     = occ_reg - 1'b1;
                                rd_pend_next = 1'b1;
                                rd_last_next = 1'b1;
                            end
                        end
                        MODE_POP_REAR: begin
                            if (q_empty) begin
                                imm_valid      = 1'b1;
                                imm_res.status = ST_EMPTY;
                            end else begin
                                ram_re       = 1'b1;
                                ram_raddr    = ring_add(head_reg, IDX_W'(occ_reg - 1'b1));
                                occ_next     = occ_reg - 1'b1;
                                rd_pend_next = 1'b1;
                                rd_last_next = 1'b1;
                            end
                        end
                        MODE_LIST: begin
                            if (q_empty) begin
                                imm_valid      = 1'b1;
                                imm_res.status = ST_EMPTY;
                            end else begin
                                list_idx_next = '0;
                                state_next    = S_LIST;
                            end
                        end
                        default: ;  // unused codes: drop the word
                    endcase
                end
            end
            S_LIST: begin
                // One store read a cycle while the FIFO has room
                if (issue_ok) begin
                    ram_re       = 1'b1;
                    ram_raddr    = ring_add(head_reg, list_idx_reg);
                    rd_pend_next = 1'b1;
                    if ({1'b0, list_idx_reg} == (IDX_W + 1)'(occ_reg - 1'b1)) begin
                        rd_last_next = 1'b1;
                        state_next   = S_IDLE;
                    end else begin
                        list_idx_next = list_idx_reg + 1'b1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Read data lands in the cycle after the read; no command is taken then
    assign ob_push     = imm_valid || rd_pend_reg;
    assign ob_push_res = rd_pend_reg
                       ? res_t'{status: ST_OK, data: $signed(ram_rdata), last: rd_last_reg}
                       : imm_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            occ_reg      <= '0;
            list_idx_reg <= '0;
            rd_pend_reg  <= 1'b0;
            rd_last_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            occ_reg      <= occ_next;
            list_idx_reg <= list_idx_next;
            rd_pend_reg  <= rd_pend_next;
            rd_last_reg  <= rd_last_next;
        end
    end

    bdeq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_tdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bdeq_obuf u_obuf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (ob_push),
        .push_res   (ob_push_res),
        .pop_ready  (m_tready),
        .head_valid (ob_head_valid),
        .head_res   (ob_head_res),
        .count      (ob_count),
        .full       (ob_full)
    );

    assign m_tvalid = ob_head_valid;
    assign m_tdata  = ob_head_res.data;
    assign m_tuser  = ob_head_res.status;
    assign m_tlast  = ob_head_res.last;

`ifndef SYNTH
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_FULL)
        else $error("occupancy beyond depth");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ob_push |-> !ob_full)
        else $error("result pushed into full buffer");

    a_list_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LIST) |-> !q_empty)
        else $error("listing an empty queue");

    a_one_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !(imm_valid && rd_pend_reg))
        else $error("immediate result collides with read data");

    a_read_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_re |=> ob_push)
        else $error("store read not posted next cycle");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the bounded double-ended queue: a shadow deque predicts
// every result word and checks it. Depends on bdeq_pkg and bounded_double_ended_queue_top.
module testbench;
    import bdeq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int RANDOM_CMDS = 420;
    localparam int IDLE_LIMIT  = 2000;  // cycles with no word moving on either side
    localparam int SETTLE      = 20;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_tvalid;
    logic                        s_tready;
    logic signed [VALUE_W-1:0]   s_tdata;   // [31:0] value
    logic [MODE_W-1:0]           s_tuser;   // [2:0] mode
    logic                        m_tvalid;
    logic                        m_tready;
    logic signed [VALUE_W-1:0]   m_tdata;   // [31:0] data
    logic [STATUS_W-1:0]         m_tuser;   // [1:0] status
    logic                        m_tlast;

    // Shadow copy of the deque: notes each accepted command, queues the result
    // words it must cause, and checks returned words against the oldest one.
    class deque_shadow;
        logic signed [VALUE_W-1:0] ring[DEPTH];
        int unsigned               front_slot;
        int unsigned               fill;
        res_t                      awaited_words[$];
        int                        errors;
        int                        n_commands, n_words, n_full, n_empty, n_listings;

        function void await_word(logic [STATUS_W-1:0] status,
                                 logic signed [VALUE_W-1:0] data, logic last);
            res_t w;
            w.status = status;
            w.data   = data;
            w.last   = last;
            awaited_words.push_back(w);
        endfunction

        function void note_command(logic [MODE_W-1:0] mode, logic signed [VALUE_W-1:0] value);
            n_commands++;
            case (mode)
                MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
                    if (fill >= DEPTH) begin
                        await_word(ST_FULL, '0, 1'b1);
                    end else begin
                        if (mode == MODE_PUSH_FRONT) begin
                            front_slot = (front_slot + DEPTH - 1) % DEPTH;
                            ring[front_slot] = value;
                        end else begin
                            ring[(front_slot + fill) % DEPTH] = value;
                        end
                        fill++;
                        await_word(ST_OK, '0, 1'b1);
                    end
                end
                MODE_POP_FRONT, MODE_POP_REAR: begin
                    if (fill == 0) begin
                        await_word(ST_EMPTY, '0, 1'b1);
                    end else if (mode == MODE_POP_FRONT) begin
                        await_word(ST_OK, ring[front_slot], 1'b1);
                        front_slot = (front_slot + 1) % DEPTH;
                        fill--;
                    end else begin
                        await_word(ST_OK, ring[(front_slot + fill - 1) % DEPTH], 1'b1);
                        fill--;
                    end
                end
                MODE_LIST: begin
                    n_listings++;
                    if (fill == 0) begin
                        await_word(ST_EMPTY, '0, 1'b1);
                    end else begin
                        for (int i = 0; i < fill; i++) begin
                            await_word(ST_OK, ring[(front_slot + i) % DEPTH], i == fill - 1);
                        end
                    end
                end
                default: begin
                    // unused codes leave the queue alone and give no word
                end
            endcase
        endfunction

        function void check_word(logic [STATUS_W-1:0] status,
                                 logic signed [VALUE_W-1:0] data, logic last);
            res_t exp_w;
            n_words++;
            if (awaited_words.size() == 0) begin
                $error("result word with nothing awaited: status %0d data %0d last %0d",
                       status, data, last);
                errors++;
                return;
            end
            exp_w = awaited_words.pop_front();
            if (exp_w.status == ST_FULL) n_full++;
            if (exp_w.status == ST_EMPTY) n_empty++;
            if (status !== exp_w.status) begin
                $error("status: expected %0d, got %0d", exp_w.status, status);
                errors++;
            end
            if (data !== exp_w.data) begin
                $error("data: expected %0d, got %0d", exp_w.data, data);
                errors++;
            end
            if (last !== exp_w.last) begin
                $error("last: expected %0d, got %0d", exp_w.last, last);
                errors++;
            end
        endfunction
    endclass

    deque_shadow shadow = new;

    bit src_quiet;    // sender puts no gap before a command while set
    bit sink_steady;  // receiver starts no new stall while set
    int idle_cycles;

    bounded_double_ended_queue_top #(
        .DEPTH(DEPTH)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Sample both channels at the rising edge. Check the outgoing word before
    // noting the incoming command, so a stray word cannot match a fresh entry.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) shadow.check_word(m_tuser, m_tdata, m_tlast);
            if (s_tvalid && s_tready) shadow.note_command(s_tuser, s_tdata);
        end
    end

    // Watchdog: abandon the run once nothing has moved for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver: hold tready low for random stretches, change only at the falling edge.
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
                stall_left = ($urandom_range(3) == 0) ? pick_gap(sink_steady) : 0;
            end
        end
    end

    // Offer one command word after a random gap; return at the falling edge
    // after it was taken, leaving tvalid high so back-to-back words need no dip.
    task automatic send_command(input logic [MODE_W-1:0] mode,
                                input logic signed [VALUE_W-1:0] value);
        int gap;
        gap = pick_gap(src_quiet);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = mode;
        s_tdata  = value;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Hold the sender off until every awaited word has come back.
    task automatic drain_results();
        s_tvalid = 1'b0;
        while (shadow.awaited_words.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom();
        endcase
    endfunction

    initial begin
        int counted, burst_len, bias, push_pct, r;
        logic [MODE_W-1:0] mode;

        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        src_quiet   = 1'b0;
        sink_steady = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty flags on every reader, rear push into an empty queue popped from the front,
        // then fill to the brim with extreme and small words, overflow both ends, list.
        send_command(MODE_LIST, '0);
        send_command(MODE_POP_FRONT, '0);
        send_command(MODE_POP_REAR, -32'sd1);
        send_command(MODE_PUSH_REAR, 32'sh7FFF_FFFF);
        send_command(MODE_POP_FRONT, '0);
        for (int i = 0; i < DEPTH; i++) begin
            case (i % 4)
                0: send_command(MODE_PUSH_FRONT, 32'sh8000_0000);
                1: send_command(MODE_PUSH_REAR, 32'sh7FFF_FFFF);
                2: send_command(MODE_PUSH_FRONT, -32'sd1 - i);
                default: send_command(MODE_PUSH_REAR, i);
            endcase
        end
        send_command(MODE_PUSH_FRONT, 32'sh1234_5678);
        send_command(MODE_PUSH_REAR, -32'sd1);
        send_command(MODE_LIST, '0);
        // unused codes: no word back, queue untouched
        send_command(3'd5, '0);
        send_command(3'd6, 32'sh5555_5555);
        send_command(3'd7, -32'sd1);
        drain_results();

        // Random bursts, each leaning towards filling, draining or neither,
        // with the idle pattern on both sides switched per burst.
        counted = 0;
        while (counted < RANDOM_CMDS) begin
            bias        = $urandom_range(2);
            push_pct    = (bias == 0) ? 75 : (bias == 1) ? 25 : 50;
            burst_len   = $urandom_range(8, 40);
            src_quiet   = ($urandom_range(3) == 0);
            sink_steady = ($urandom_range(3) == 0);
            for (int k = 0; k < burst_len && counted < RANDOM_CMDS; k++) begin
                r = $urandom_range(99);
                if (r < 3) begin
                    mode = MODE_W'($urandom_range(5, 7));
                end else begin
                    counted++;
                    if (r < 13) begin
                        mode = MODE_LIST;
                    end else if ($urandom_range(99) < push_pct) begin
                        mode = $urandom_range(1) ? MODE_PUSH_REAR : MODE_PUSH_FRONT;
                    end else begin
                        mode = $urandom_range(1) ? MODE_POP_REAR : MODE_POP_FRONT;
                    end
                end
                send_command(mode, pick_value());
            end
            if ($urandom_range(5) == 0) drain_results();
        end

        // Drain, then let the pipeline settle before judging.
        s_tvalid  = 1'b0;
        src_quiet = 1'b0;
        while (shadow.awaited_words.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        $display("covered %0d commands (%0d listings) and %0d result words",
                 shadow.n_commands, shadow.n_listings, shadow.n_words);
        $display("flagged words seen: %0d overflow drops, %0d empty reads",
                 shadow.n_full, shadow.n_empty);
        if (shadow.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/bdeq_pkg.sv
src/bdeq_ram.sv
src/bdeq_obuf.sv
src/bounded_double_ended_queue_top.sv
bench/testbench.sv
